/* sv/scalar_kalman_three_channel_top_macros.svh */
// Assertion macros shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_THREE_CHANNEL_TOP_MACROS_SVH
`define SCALAR_KALMAN_THREE_CHANNEL_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset
`define SKF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/skf_pkg.sv */
// Types, constants and register codes for the scalar Kalman filter.
package skf_pkg;

  // Field and data widths
  localparam int DATA_W    = 32;
  localparam int CH_W      = 2;
  localparam int GAIN_W    = 17;
  localparam int CFG_IDX_W = 3;

  // Channels that own configuration registers
  localparam int CFG_CH = 3;

  // Parameter defaults
  localparam int CHANNELS_DEF  = 3;
  localparam int FRAC_BITS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR_VOLT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR_CURR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_ERR_TEMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_VOLT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_CURR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_TEMP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST_ERR  = 3'd6;

  // Register reset values
  localparam logic [DATA_W-1:0] MEAS_ERR_RST = 32'd65536;
  localparam logic [DATA_W-1:0] NOISE_RST    = 32'd655;
  localparam logic [DATA_W-1:0] INIT_ERR_RST = 32'd65536;

  localparam logic [DATA_W-1:0] ERR_MAX = {DATA_W{1'b1}};

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FIN
  } skf_state_t;

  // Divider request and status
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W:0]   den;
  } skf_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } skf_div_stat_t;

endpackage

/* sv/skf_if.sv */
// Valid/ready stream interfaces for filter samples and filter results.
interface skf_in_if
  import skf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel;
  logic signed [DATA_W-1:0] measurement;

  modport source (output valid, channel, measurement, input ready);
  modport sink   (input valid, channel, measurement, output ready);
endinterface

interface skf_out_if
  import skf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate;
  logic [GAIN_W-1:0]        gain;
  logic [DATA_W-1:0]        est_error;
  logic                     bad_channel;

  modport source (output valid, estimate, gain, est_error, bad_channel, input ready);
  modport sink   (input valid, estimate, gain, est_error, bad_channel, output ready);
endinterface

/* sv/skf_div.sv */
// Bit-serial restoring divider for the gain: floor(num * 2^FRAC_BITS / den).
module skf_div
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  skf_div_req_t     req,
  output skf_div_stat_t    stat,
  output logic [FRAC_BITS:0] quot
);

  localparam int Q_W   = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(Q_W);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(1);

  logic [DATA_W+1:0] rem_r, rem_nxt;
  logic [DATA_W:0]   den_r, den_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;
  logic [DATA_W+1:0] rem_sub;

  // One quotient bit per cycle, MSB first; zero divisor yields zero
  always_comb begin
    ge       = (rem_r >= {1'b0, den_r}) && (den_r != '0);
    rem_sub  = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = {2'b00, req.num};
      den_nxt  = req.den;
      q_nxt    = '0;
      cnt_nxt  = CNT_START;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = {rem_sub[DATA_W:0], 1'b0};
      q_nxt   = {q_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_LAST;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

/* sv/scalar_kalman_three_channel_top.sv */
// Scalar Kalman filter for three sensor channels with a shared sequenced datapath.
// A transaction runs S_LOAD, the bit-serial gain divider (S_DIV), then three passes through the
// single 32x32 multiplier (S_MUL1 to S_MUL3) and S_FIN; a new one is taken only back in S_IDLE.
// An invalid channel goes from S_IDLE straight to S_FIN, answers there and leaves state untouched.
// Reset (rst_n, synchronous, active low): registers to defaults, estimates to zero,
// estimate errors to the init_est_err default.
`include "scalar_kalman_three_channel_top_macros.svh"

module scalar_kalman_three_channel_top
  import skf_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  skf_in_if.sink               in_stream,
  skf_out_if.source            out_stream,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  // Channels that hold state: limited by the register set
  localparam int NCH   = (CHANNELS < CFG_CH) ? CHANNELS : CFG_CH;
  localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int G_W   = FRAC_BITS + 1;
  localparam logic [CH_W:0]  NCH_L  = (CH_W + 1)'(NCH);
  localparam logic [G_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration registers
  logic [DATA_W-1:0] meas_err_r [CFG_CH];
  logic [DATA_W-1:0] noise_r    [CFG_CH];

  // Channel state
  logic signed [DATA_W-1:0] est_r [NCH];
  logic [DATA_W-1:0]        err_r [NCH];

  // Sequencer
  skf_state_t state_r, state_nxt;

  // Working registers for the current transaction
  logic [CH_W-1:0]          ch_r;
  logic signed [DATA_W-1:0] mea_r;
  logic                     bad_r;
  logic [DATA_W-1:0]        cur_err_r;
  logic [DATA_W-1:0]        cur_noise_r;
  logic signed [DATA_W-1:0] last_r;
  logic                     neg_r;
  logic [DATA_W:0]          mag_r;
  logic [G_W-1:0]           g_r;
  logic [DATA_W:0]          p_r;
  logic [DATA_W-1:0]        t1_r;
  logic signed [DATA_W-1:0] next_r;

  // Shared multiplier
  logic [DATA_W-1:0]   mul_a, mul_b;
  logic [2*DATA_W-1:0] prod_r;

  // Output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_est_r;
  logic [GAIN_W-1:0]        out_gain_r;
  logic [DATA_W-1:0]        out_err_r;
  logic                     out_bad_r;

  // Divider hookup
  skf_div_req_t      div_req;
  skf_div_stat_t     div_stat;
  logic [FRAC_BITS:0] div_quot;

  logic              in_ready;
  logic              in_fire;
  logic              out_free;
  logic              ch_ok;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W:0]   diff33;
  logic [2*DATA_W-1:0] gm_sum;
  logic [DATA_W:0]   next33;
  logic [2*DATA_W:0] pn_full;
  logic [DATA_W-1:0] t2;
  logic [DATA_W:0]   sum33;
  logic [DATA_W-1:0] err_sum;
  logic [G_W-1:0]    one_minus_g;

  skf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  assign in_fire  = in_stream.valid && in_ready;
  assign ch_ok    = {1'b0, in_stream.channel} < NCH_L;
  assign idx      = ch_r[IDX_W-1:0];
  assign out_free = !out_valid_r || out_stream.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = ch_ok ? S_LOAD : S_FIN;
        end
      end
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider start, multiplier operands
  always_comb begin
    one_minus_g   = ONE_FX - g_r;
    in_ready      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = err_r[idx];
    div_req.den   = {1'b0, err_r[idx]} + {1'b0, meas_err_r[ch_r]};
    mul_a         = p_r[DATA_W-1:0];
    mul_b         = cur_noise_r;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_LOAD: div_req.start = 1'b1;
      S_MUL1: begin
        mul_a = DATA_W'(g_r);
        mul_b = mag_r[DATA_W-1:0];
      end
      S_MUL2: begin
        mul_a = DATA_W'(one_minus_g);
        mul_b = cur_err_r;
      end
      default: begin
        mul_a = p_r[DATA_W-1:0];
        mul_b = cur_noise_r;
      end
    endcase
  end

  // Arithmetic around the multiplier
  always_comb begin
    diff33  = {mea_r[DATA_W-1], mea_r} - {last_r[DATA_W-1], last_r};
    // g * mag, adding the term for a magnitude of exactly 2^32
    gm_sum  = prod_r + (mag_r[DATA_W] ? ((2*DATA_W)'(g_r) << DATA_W) : '0);
    next33  = neg_r ? ({last_r[DATA_W-1], last_r} - p_r)
                    : ({last_r[DATA_W-1], last_r} + p_r);
    // p * noise, with the top bit of p as a shifted add
    pn_full = {1'b0, prod_r}
            + (p_r[DATA_W] ? {1'b0, cur_noise_r, {DATA_W{1'b0}}} : '0);
    t2      = (|pn_full[2*DATA_W:FRAC_BITS+DATA_W]) ? ERR_MAX
                                                     : pn_full[FRAC_BITS +: DATA_W];
    sum33   = {1'b0, t1_r} + {1'b0, t2};
    err_sum = sum33[DATA_W] ? ERR_MAX : sum33[DATA_W-1:0];
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_CH; i++) begin
        meas_err_r[i] <= MEAS_ERR_RST;
        noise_r[i]    <= NOISE_RST;
      end
      for (int i = 0; i < NCH; i++) begin
        est_r[i] <= '0;
        err_r[i] <= INIT_ERR_RST;
      end
    end else begin
      // Write back the updated channel
      if (state_r == S_FIN && out_free && !bad_r) begin
        est_r[idx] <= next_r;
        err_r[idx] <= err_sum;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MEAS_ERR_VOLT: meas_err_r[0] <= cfg_data;
          REG_MEAS_ERR_CURR: meas_err_r[1] <= cfg_data;
          REG_MEAS_ERR_TEMP: meas_err_r[2] <= cfg_data;
          REG_NOISE_VOLT:    noise_r[0]    <= cfg_data;
          REG_NOISE_CURR:    noise_r[1]    <= cfg_data;
          REG_NOISE_TEMP:    noise_r[2]    <= cfg_data;
          REG_INIT_EST_ERR: begin
            // Only loads the channel errors; there is no read-back
            for (int i = 0; i < NCH; i++) begin
              err_r[i] <= cfg_data;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ch_r  <= in_stream.channel;
          mea_r <= in_stream.measurement;
          bad_r <= !ch_ok;
        end
      end
      S_LOAD: begin
        cur_err_r   <= err_r[idx];
        cur_noise_r <= noise_r[ch_r];
        last_r      <= est_r[idx];
      end
      S_DIV: begin
        // diff is taken from last_r, loaded in S_LOAD
        neg_r <= diff33[DATA_W];
        mag_r <= diff33[DATA_W] ? (~diff33 + 1'b1) : diff33;
        if (div_stat.done) begin
          g_r <= div_quot;
        end
      end
      S_MUL2: p_r <= gm_sum[FRAC_BITS +: DATA_W + 1];
      S_MUL3: begin
        t1_r   <= prod_r[FRAC_BITS +: DATA_W];
        next_r <= next33[DATA_W-1:0];
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      if (bad_r) begin
        out_est_r  <= '0;
        out_gain_r <= '0;
        out_err_r  <= '0;
        out_bad_r  <= 1'b1;
      end else begin
        out_est_r  <= next_r;
        out_gain_r <= GAIN_W'(g_r);
        out_err_r  <= err_sum;
        out_bad_r  <= 1'b0;
      end
    end
  end

  assign in_stream.ready        = in_ready;
  assign out_stream.valid       = out_valid_r;
  assign out_stream.estimate    = out_est_r;
  assign out_stream.gain        = out_gain_r;
  assign out_stream.est_error   = out_err_r;
  assign out_stream.bad_channel = out_bad_r;

  // Checks
  `SKF_ASSERT_NXT(a_busy_after_accept, in_stream.valid && in_stream.ready, !in_stream.ready, "input accepted while a transaction is in flight")
  `SKF_ASSERT_NXT(a_fin_holds, state_r == S_FIN && !out_free, state_r == S_FIN, "finished result dropped while output was full")
  `SKF_ASSERT_IMP(a_gain_le_one, state_r == S_MUL1, g_r <= ONE_FX, "gain above one")
  `SKF_ASSERT_IMP(a_bad_zero, out_valid_r && out_bad_r, out_est_r == '0 && out_gain_r == '0 && out_err_r == '0, "invalid channel result not zero")

endmodule

/* tb/scalar_kalman_three_channel_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the three-channel scalar Kalman filter: predicts and compares every result.
module scalar_kalman_three_channel_top_tb;
  import skf_pkg::*;

  // Channel codes and the register index with no register behind it
  localparam logic [CH_W-1:0]      CH_VOLT    = 2'd0;
  localparam logic [CH_W-1:0]      CH_CURR    = 2'd1;
  localparam logic [CH_W-1:0]      CH_TEMP    = 2'd2;
  localparam logic [CH_W-1:0]      CH_BAD     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int NUM_CH       = CHANNELS_DEF;
  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 30;
  localparam int SETTLE       = 4;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] measurement;
  } filt_sample_t;

  typedef struct {
    logic signed [DATA_W-1:0] estimate;
    logic [GAIN_W-1:0]        gain;
    logic [DATA_W-1:0]        est_error;
    logic                     bad_channel;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  skf_in_if  in_if ();
  skf_out_if out_if ();

  scalar_kalman_three_channel_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor state: filter state plus a mirror of the registers
  logic signed [DATA_W-1:0] filt_estimate [NUM_CH];
  logic [DATA_W-1:0]        filt_error    [NUM_CH];
  logic [DATA_W-1:0]        meas_err_cfg  [CFG_CH];
  logic [DATA_W-1:0]        noise_cfg     [CFG_CH];
  logic [DATA_W-1:0]        init_err_cfg;

  filt_sample_t pending_samples[$];
  filt_result_t predicted_results[$];
  filt_sample_t next_sample;
  filt_sample_t taken_sample;
  filt_result_t want;

  int  mismatch_count = 0;
  int  idle_cycles;
  int  send_gap;
  int  hold_left;
  int  sink_draw;
  int  holds_asked = 0;
  int  holds_served;
  bit  src_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;
  logic signed [DATA_W-1:0] walk_base [CFG_CH];
  int  walk_span = 16;

  initial begin
    forever #2 clk = ~clk;
  end

  // One filter update: gain, estimate move, new error with saturation
  function automatic filt_result_t predict_filter_step(input filt_sample_t smp);
    filt_result_t      r;
    logic [63:0]       err, merr, nz, denom, g, mag, p, t1, t2, sum;
    logic [127:0]      nprod, nshift;
    logic signed [63:0] last, diff, nxt;
    r = '{default: '0};
    if (smp.channel >= NUM_CH || smp.channel >= CFG_CH) begin
      r.bad_channel = 1'b1;
      return r;
    end
    err   = 64'(filt_error[smp.channel]);
    merr  = 64'(meas_err_cfg[smp.channel]);
    nz    = 64'(noise_cfg[smp.channel]);
    last  = filt_estimate[smp.channel];
    denom = err + merr;
    g     = (denom == 0) ? 64'd0 : (err << FRAC) / denom;
    diff  = smp.measurement;
    diff  = diff - last;
    mag   = (diff < 0) ? -diff : diff;
    p     = (g * mag) >> FRAC;
    nxt   = (diff < 0) ? last - $signed(p) : last + $signed(p);
    t1    = (((64'd1 << FRAC) - g) * err) >> FRAC;
    nprod = {64'd0, p} * {64'd0, nz};
    nshift = nprod >> FRAC;
    t2    = (nshift > 128'(ERR_MAX)) ? 64'(ERR_MAX) : nshift[63:0];
    sum   = t1 + t2;
    if (sum > 64'(ERR_MAX)) sum = 64'(ERR_MAX);
    filt_estimate[smp.channel] = nxt[DATA_W-1:0];
    filt_error[smp.channel]    = sum[DATA_W-1:0];
    r.estimate  = nxt[DATA_W-1:0];
    r.gain      = g[GAIN_W-1:0];
    r.est_error = sum[DATA_W-1:0];
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  // Register value: extremes, full range, or a typical small value
  function automatic logic [DATA_W-1:0] pick_cfg_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ERR_MAX;
      2: return $urandom;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  // Register write, mirrored into the predictor at the same edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MEAS_ERR_VOLT: meas_err_cfg[CH_VOLT] = val;
      REG_MEAS_ERR_CURR: meas_err_cfg[CH_CURR] = val;
      REG_MEAS_ERR_TEMP: meas_err_cfg[CH_TEMP] = val;
      REG_NOISE_VOLT:    noise_cfg[CH_VOLT]    = val;
      REG_NOISE_CURR:    noise_cfg[CH_CURR]    = val;
      REG_NOISE_TEMP:    noise_cfg[CH_TEMP]    = val;
      REG_INIT_EST_ERR: begin
        init_err_cfg = val;
        for (int c = 0; c < NUM_CH; c++) filt_error[c] = val;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_regs(input logic [DATA_W-1:0] mv, mc, mt, nv, nc, nt, ie);
    cfg_write(REG_MEAS_ERR_VOLT, mv);
    cfg_write(REG_MEAS_ERR_CURR, mc);
    cfg_write(REG_MEAS_ERR_TEMP, mt);
    cfg_write(REG_NOISE_VOLT, nv);
    cfg_write(REG_NOISE_CURR, nc);
    cfg_write(REG_NOISE_TEMP, nt);
    cfg_write(REG_INIT_EST_ERR, ie);
  endtask

  task automatic add_sample(input logic [CH_W-1:0] ch, input logic signed [DATA_W-1:0] m);
    filt_sample_t s;
    s.channel     = ch;
    s.measurement = m;
    pending_samples.push_back(s);
  endtask

  // Block until every queued transaction is through and answered
  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_if.valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Sensor-like traces: slow random walk per channel, some noise and junk
  task automatic queue_random_items(input int count);
    logic [CH_W-1:0]          ch;
    logic [CH_W-1:0]          slot;
    logic signed [DATA_W-1:0] m;
    int                       drift;
    int                       jit;
    for (int i = 0; i < count; i++) begin
      ch = ($urandom_range(0, 15) == 0) ? CH_BAD : CH_W'($urandom_range(CH_VOLT, CH_TEMP));
      case ($urandom_range(0, 19))
        0, 1, 2: m = $urandom;
        3: begin
          case ($urandom_range(0, 3))
            0: m = 32'h7FFF_FFFF;
            1: m = 32'h8000_0000;
            2: m = '0;
            default: m = '1;
          endcase
        end
        default: begin
          slot  = (ch == CH_BAD) ? CH_VOLT : ch;
          drift = int'($urandom_range(0, 2 * walk_span)) - walk_span;
          jit   = int'($urandom_range(0, 2 * walk_span)) - walk_span;
          walk_base[slot] = walk_base[slot] + drift;
          m = walk_base[slot] + jit;
        end
      endcase
      add_sample(ch, m);
    end
  endtask

  // Driver: offers queued samples with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid       <= 1'b0;
      in_if.channel     <= '0;
      in_if.measurement <= '0;
      send_gap          <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        next_sample        = pending_samples.pop_front();
        in_if.valid       <= 1'b1;
        in_if.channel     <= next_sample.channel;
        in_if.measurement <= next_sample.measurement;
        send_gap          <= pick_gap(src_idle_on);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      sink_draw = out_if.ready ? pick_gap(sink_idle_on) : 0;
      out_if.ready <= (sink_draw == 0);
      hold_left    <= (sink_draw == 0) ? 0 : sink_draw - 1;
    end
  end

  // Input monitor: predict the result of each accepted sample
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      taken_sample.channel     = in_if.channel;
      taken_sample.measurement = in_if.measurement;
      predicted_results.push_back(predict_filter_step(taken_sample));
    end
  end

  // Output monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with nothing predicted: est=%0d gain=%0d err=%0d bad=%0b",
                   $realtime, out_if.estimate, out_if.gain, out_if.est_error,
                   out_if.bad_channel);
      end else begin
        want = predicted_results.pop_front();
        if (out_if.estimate !== want.estimate || out_if.gain !== want.gain ||
            out_if.est_error !== want.est_error || out_if.bad_channel !== want.bad_channel)
        begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected est=%0d gain=%0d err=%0d bad=%0b, got est=%0d gain=%0d err=%0d bad=%0b",
                     $realtime, want.estimate, want.gain, want.est_error, want.bad_channel,
                     out_if.estimate, out_if.gain, out_if.est_error, out_if.bad_channel);
        end
      end
    end
  end

  // Watchdog: too long with no transaction on any port
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed corners, then randomized configuration phases
  initial begin
    init_err_cfg      = INIT_ERR_RST;
    for (int c = 0; c < CFG_CH; c++) begin
      meas_err_cfg[c] = MEAS_ERR_RST;
      noise_cfg[c]    = NOISE_RST;
      walk_base[c]    = '0;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      filt_estimate[c] = '0;
      filt_error[c]    = INIT_ERR_RST;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: full-scale swings and the invalid channel
    add_sample(CH_VOLT, 32'h7FFF_FFFF);
    add_sample(CH_VOLT, 32'h8000_0000);
    add_sample(CH_CURR, 32'h0000_0000);
    add_sample(CH_CURR, 32'hFFFF_FFFF);
    add_sample(CH_TEMP, 32'h0001_0000);
    add_sample(CH_TEMP, 32'h8000_0000);
    add_sample(CH_BAD, 32'h7FFF_FFFF);
    add_sample(CH_BAD, 32'h8000_0000);
    add_sample(CH_VOLT, 32'h0000_0000);
    wait_drained();

    // Everything at maximum: error terms saturate
    write_regs(ERR_MAX, ERR_MAX, ERR_MAX, ERR_MAX, ERR_MAX, ERR_MAX, ERR_MAX);
    add_sample(CH_VOLT, 32'h8000_0000);
    add_sample(CH_VOLT, 32'h7FFF_FFFF);
    add_sample(CH_CURR, 32'h7FFF_FFFF);
    add_sample(CH_CURR, 32'h8000_0000);
    add_sample(CH_TEMP, 32'h7FFF_FFFF);
    add_sample(CH_TEMP, 32'h0000_0000);
    wait_drained();

    // Everything zero: zero denominator, estimate holds
    write_regs('0, '0, '0, '0, '0, '0, '0);
    add_sample(CH_VOLT, 32'h1234_5678);
    add_sample(CH_CURR, 32'h8000_0000);
    add_sample(CH_TEMP, 32'hFFFF_FFFF);
    wait_drained();

    // No measurement error: gain of one; unused index written too
    write_regs('0, '0, '0, ERR_MAX, ERR_MAX, ERR_MAX, 32'h0001_0000);
    cfg_write(REG_UNUSED, $urandom);
    add_sample(CH_VOLT, 32'h7FFF_FFFF);
    add_sample(CH_CURR, 32'h8000_0000);
    add_sample(CH_TEMP, 32'h0040_0000);
    add_sample(CH_VOLT, 32'h8000_0000);
    wait_drained();

    // Random phases; one without idling, one with a long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      write_regs(pick_cfg_value(), pick_cfg_value(), pick_cfg_value(), pick_cfg_value(),
                 pick_cfg_value(), pick_cfg_value(), pick_cfg_value());
      if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, $urandom);
      src_idle_on  = (ph != 2);
      sink_idle_on = (ph != 2);
      case (ph % 3)
        0: walk_span = 16;
        1: walk_span = 4096;
        default: walk_span = 1 << 20;
      endcase
      for (int c = 0; c < CFG_CH; c++)
        walk_base[c] = $signed($urandom) >>> $urandom_range(0, 15);
      queue_random_items(270);
      if (ph == 4) begin
        while (predicted_results.size() == 0) @(negedge clk);
        holds_asked = holds_asked + 1;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
